// File: hdl/cfrb_pkg.sv
// Shared constants, codes and types of the command frame ring buffer.
package cfrb_pkg;

  localparam int RING_DEPTH   = 256;
  localparam int PTR_W        = $clog2(RING_DEPTH);
  localparam int MAX_CMD_LEN  = 32;
  localparam int LEN_W        = $clog2(MAX_CMD_LEN + 1);
  localparam int CFG_W        = 6;
  localparam int BYTE_W       = 8;
  localparam int REPEAT_LIMIT = 4;
  localparam int REP_W        = $clog2(REPEAT_LIMIT + 1);
  localparam int ARG_CMD_BASE = 128;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CFG_W-1:0]  cfg_val_t;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DATA  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_DROP  = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    REG_FIND_LEN = 1'b0,
    REG_JUMP_LEN = 1'b1
  } cfg_reg_e;

  // Clamped command lengths handed to the controller.
  typedef struct packed {
    len_t find_len;
    len_t jump_len;
  } cfg_t;

endpackage

// File: hdl/cfrb_if.sv
// Valid/ready channel interfaces: input items, result items, register writes.
interface cfrb_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          command;
  cfrb_pkg::byte_t     rx_byte;
  logic                end_of_chunk;
  logic                new_drain;

  modport source (output valid, command, rx_byte, end_of_chunk, new_drain, input ready);
  modport sink   (input valid, command, rx_byte, end_of_chunk, new_drain, output ready);
endinterface

interface cfrb_out_if;
  logic                valid;
  logic                ready;
  cfrb_pkg::byte_t     out_byte;
  logic [1:0]          status;
  logic                last;

  modport source (output valid, out_byte, status, last, input ready);
  modport sink   (input valid, out_byte, status, last, output ready);
endinterface

interface cfrb_cfg_if;
  logic                  valid;
  logic                  ready;
  cfrb_pkg::cfg_reg_e    index;
  cfrb_pkg::cfg_val_t    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/command_frame_ring_buffer.sv
// Top level of the command frame ring buffer: length registers, store and controller.
//
// Byte ring buffer that only lets whole commands through to the reader. Push
// and clear items may follow back to back; a push is one write into the store.
// A pop fetches the command byte through the store's registered read port,
// decodes it and then returns one result per cycle while the result side
// accepts them; no further item is taken until the pop has ended, be it with
// data bytes, an empty result or a dropped repeat. Each returned byte is one
// read of the store. Results sit in an output register, so a push may be
// taken while the last result still waits. The store is not cleared after
// reset and needs no start-up pass. Command lengths of zero read as 1 and
// lengths above the maximum read as the maximum; a pop never reads past the
// last committed byte. Write the length registers only while the block is
// idle.
module command_frame_ring_buffer (
  input  logic          clk_i,
  input  logic          rst_ni,
  cfrb_in_if.sink       in_ch,
  cfrb_out_if.source    out_ch,
  cfrb_cfg_if.sink      cfg_ch
);
  import cfrb_pkg::*;

  localparam int CMP_W = (CFG_W > LEN_W) ? CFG_W : LEN_W;

  // Map a raw register value onto the legal length range.
  function automatic len_t clamp_len(cfg_val_t v);
    logic [CMP_W-1:0] ext;
    ext = CMP_W'(v);
    if (ext == '0) begin
      return len_t'(1);
    end else if (ext > CMP_W'(MAX_CMD_LEN)) begin
      return len_t'(MAX_CMD_LEN);
    end
    return len_t'(ext);
  endfunction

  cfg_val_t find_len_q, jump_len_q;
  cfg_t     cfg;

  logic     ram_we;
  ptr_t     ram_waddr;
  byte_t    ram_wdata;
  logic     ram_re;
  ptr_t     ram_raddr;
  byte_t    ram_rdata;

  // Register writes are always taken.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      find_len_q <= CFG_W'(1);
      jump_len_q <= CFG_W'(1);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_FIND_LEN: find_len_q <= cfg_ch.data;
        REG_JUMP_LEN: jump_len_q <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  // Clamp once here; the controller sees legal lengths only.
  assign cfg.find_len = clamp_len(find_len_q);
  assign cfg.jump_len = clamp_len(jump_len_q);

  cfrb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cfrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_i       (cfg),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // A store write only ever comes from an accepted push item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (in_ch.valid && in_ch.ready && in_ch.command == CMD_PUSH))
    else $error("store written without an accepted push");

  // The store's two ports are never busy in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("store read and write in the same cycle");

  // Once a pop is taken, hold off further items until it has finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready && in_ch.command == CMD_POP) |=> !in_ch.ready)
    else $error("item taken while a pop is in progress");

  // Hold the pop open while a byte fetched mid-pop is still to be returned.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_re && !in_ch.ready) |=> !in_ch.ready)
    else $error("pop ended in the cycle after a byte fetch");

endmodule

// File: hdl/cfrb_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
module cfrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Hold the last read word until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: hdl/cfrb_ctrl.sv
// Pointer, commit and pop sequencing logic around the ring store.
module cfrb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  cfrb_in_if.sink          in_ch,
  cfrb_out_if.source       out_ch,
  input  cfrb_pkg::cfg_t   cfg_i,
  output logic             ram_we_o,
  output cfrb_pkg::ptr_t   ram_waddr_o,
  output cfrb_pkg::byte_t  ram_wdata_o,
  output logic             ram_re_o,
  output cfrb_pkg::ptr_t   ram_raddr_o,
  input  cfrb_pkg::byte_t  ram_rdata_i
);
  import cfrb_pkg::*;

  localparam int SUM_W = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EMPTY = 5'b00010,
    S_HEAD  = 5'b00100,
    S_DATA  = 5'b01000,
    S_DROP  = 5'b10000
  } state_e;

  function automatic len_t cmd_len(byte_t b, cfg_t c);
    if (b == BYTE_W'(ARG_CMD_BASE)) begin
      return c.find_len;
    end else if (b == BYTE_W'(ARG_CMD_BASE + 1)) begin
      return c.jump_len;
    end
    return len_t'(1);
  endfunction

  function automatic ptr_t ptr_inc(ptr_t p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
  endfunction

  // Offset below the depth, so one compare and subtract wraps it.
  function automatic ptr_t ptr_add(ptr_t p, len_t n);
    logic [SUM_W-1:0] s;
    s = SUM_W'(p) + SUM_W'(n);
    if (s >= SUM_W'(RING_DEPTH)) begin
      s = s - SUM_W'(RING_DEPTH);
    end
    return ptr_t'(s);
  endfunction

  function automatic ptr_t ptr_dist(ptr_t c, ptr_t r);
    logic [PTR_W:0] d;
    d = {1'b0, c} - {1'b0, r};
    if (c < r) begin
      d = d + (PTR_W+1)'(RING_DEPTH);
    end
    return ptr_t'(d);
  endfunction

  state_e             state_q, state_d;
  ptr_t               rp_q, rp_d, cp_q, cp_d, wp_q, wp_d;
  len_t               pend_q, pend_d, skip_q, skip_d;
  logic               ovf_q, ovf_d;
  byte_t              prev_q, prev_d;
  logic [REP_W-1:0]   rep_q, rep_d;
  len_t               idx_q, idx_d, plen_q, plen_d;
  byte_t              cmd_q, cmd_d;
  logic               out_valid_q, out_valid_d;
  byte_t              out_byte_q, out_byte_d;
  logic [1:0]         out_status_q, out_status_d;
  logic               out_last_q, out_last_d;

  logic               slot_free;
  ptr_t               nxt;
  ptr_t               avail;
  len_t               full_len;
  len_t               idx_inc;
  len_t               pend, skip;
  logic               ovf;
  logic               drop;

  assign in_ch.ready  = (state_q == S_IDLE);
  assign out_ch.valid = out_valid_q;
  assign out_ch.out_byte = out_byte_q;
  assign out_ch.status   = out_status_q;
  assign out_ch.last     = out_last_q;

  assign ram_waddr_o = wp_q;
  assign ram_wdata_o = in_ch.rx_byte;

  always_comb begin
    state_d      = state_q;
    rp_d         = rp_q;
    cp_d         = cp_q;
    wp_d         = wp_q;
    pend_d       = pend_q;
    skip_d       = skip_q;
    ovf_d        = ovf_q;
    prev_d       = prev_q;
    rep_d        = rep_q;
    idx_d        = idx_q;
    plen_d       = plen_q;
    cmd_d        = cmd_q;
    out_valid_d  = out_valid_q && !out_ch.ready;
    out_byte_d   = out_byte_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;
    ram_we_o     = 1'b0;
    ram_re_o     = 1'b0;
    ram_raddr_o  = rp_q;
    slot_free    = !out_valid_q || out_ch.ready;
    nxt          = ptr_inc(wp_q);
    avail        = ptr_dist(cp_q, rp_q);
    full_len     = cmd_len(ram_rdata_i, cfg_i);
    idx_inc      = len_t'(idx_q + 1'b1);
    pend         = pend_q;
    skip         = skip_q;
    ovf          = ovf_q;
    drop         = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_ch.valid) begin
          unique case (in_ch.command)
            CMD_PUSH: begin
              if (!ovf) begin
                if (nxt == rp_q) begin
                  // Store full: roll back the partial command.
                  wp_d = cp_q;
                  skip = pend;
                  pend = '0;
                  ovf  = 1'b1;
                end else begin
                  if (pend == '0 && skip == '0) begin
                    pend = cmd_len(in_ch.rx_byte, cfg_i);
                  end
                  if (skip != '0) begin
                    skip = len_t'(skip - 1'b1);
                  end else begin
                    ram_we_o = 1'b1;
                    wp_d     = nxt;
                    if (pend != '0) begin
                      pend = len_t'(pend - 1'b1);
                    end
                    if (pend == '0) begin
                      cp_d = nxt;
                    end
                  end
                end
              end
              if (ovf) begin
                if (skip != '0) begin
                  skip = len_t'(skip - 1'b1);
                end else begin
                  skip = len_t'(cmd_len(in_ch.rx_byte, cfg_i) - 1'b1);
                end
              end
              if (in_ch.end_of_chunk) begin
                ovf = 1'b0;
              end
              pend_d = pend;
              skip_d = skip;
              ovf_d  = ovf;
            end
            CMD_POP: begin
              if (in_ch.new_drain) begin
                prev_d = '0;
                rep_d  = '0;
              end
              if (rp_q == cp_q) begin
                state_d = S_EMPTY;
              end else begin
                ram_re_o = 1'b1;
                idx_d    = '0;
                state_d  = S_HEAD;
              end
            end
            CMD_CLEAR: begin
              rp_d   = '0;
              cp_d   = '0;
              wp_d   = '0;
              pend_d = '0;
              skip_d = '0;
              ovf_d  = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      S_EMPTY: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_byte_d   = '0;
          out_status_d = ST_EMPTY;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_HEAD: begin
        cmd_d = ram_rdata_i;
        if (SUM_W'(avail) < SUM_W'(full_len)) begin
          plen_d = len_t'(avail);
        end else begin
          plen_d = full_len;
        end
        if (ram_rdata_i == prev_q) begin
          if (rep_q >= REP_W'(REPEAT_LIMIT)) begin
            drop = 1'b1;
          end else begin
            rep_d = REP_W'(rep_q + 1'b1);
          end
        end else begin
          rep_d  = '0;
          prev_d = ram_rdata_i;
        end
        state_d = drop ? S_DROP : S_DATA;
      end
      S_DATA: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_byte_d   = ram_rdata_i;
          out_status_d = ST_DATA;
          out_last_d   = (idx_inc == plen_q);
          if (idx_inc == plen_q) begin
            rp_d    = ptr_add(rp_q, plen_q);
            state_d = S_IDLE;
          end else begin
            ram_re_o    = 1'b1;
            ram_raddr_o = ptr_add(rp_q, idx_inc);
            idx_d       = idx_inc;
          end
        end
      end
      S_DROP: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_byte_d   = cmd_q;
          out_status_d = ST_DROP;
          out_last_d   = 1'b1;
          rp_d         = ptr_add(rp_q, plen_q);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rp_q        <= '0;
      cp_q        <= '0;
      wp_q        <= '0;
      pend_q      <= '0;
      skip_q      <= '0;
      ovf_q       <= 1'b0;
      prev_q      <= '0;
      rep_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rp_q        <= rp_d;
      cp_q        <= cp_d;
      wp_q        <= wp_d;
      pend_q      <= pend_d;
      skip_q      <= skip_d;
      ovf_q       <= ovf_d;
      prev_q      <= prev_d;
      rep_q       <= rep_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    plen_q       <= plen_d;
    cmd_q        <= cmd_d;
    out_byte_q   <= out_byte_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

endmodule
